FILE: sv/ps2mct_pkg.sv
package ps2mct_pkg;

    localparam int PACKET_LEN    = 4;
    localparam int COORD_BITS    = 12;
    localparam int BYTE_BITS     = 8;
    localparam int STEP_BITS     = 8;
    localparam int RES_BITS      = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [STEP_BITS-1:0] STEP_RESET   = STEP_BITS'(20);
    localparam logic [RES_BITS-1:0]  WIDTH_RESET  = RES_BITS'(1024);
    localparam logic [RES_BITS-1:0]  HEIGHT_RESET = RES_BITS'(768);

    // status byte bit positions
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_MIDDLE = 2;
    localparam int BIT_ALWAYS = 3;
    localparam int BIT_X_SIGN = 4;
    localparam int BIT_Y_SIGN = 5;
    localparam int BIT_X_OVF  = 6;
    localparam int BIT_Y_OVF  = 7;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STEP_SIZE     = 2'd0,
        CFG_SCREEN_WIDTH  = 2'd1,
        CFG_SCREEN_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_size;
        logic [RES_BITS-1:0]  screen_width;
        logic [RES_BITS-1:0]  screen_height;
    } cfg_t;

    typedef struct packed {
        logic                 done;
        logic [BYTE_BITS-1:0] status;
        logic [BYTE_BITS-1:0] dx;
        logic [BYTE_BITS-1:0] dy;
    } packet_t;

endpackage

FILE: sv/ps2mct_if.sv
interface ps2mct_byte_if;
    import ps2mct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] mouse_byte;

    modport source (output valid, output mouse_byte, input ready);
    modport sink (input valid, input mouse_byte, output ready);
endinterface

interface ps2mct_cursor_if;
    import ps2mct_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  left_button;
    logic                  right_button;
    logic                  middle_button;
    logic                  overflow_dropped;

    modport source (
        output valid, output cursor_x, output cursor_y, output left_button,
        output right_button, output middle_button, output overflow_dropped,
        input ready
    );
    modport sink (
        input valid, input cursor_x, input cursor_y, input left_button,
        input right_button, input middle_button, input overflow_dropped,
        output ready
    );
endinterface

FILE: sv/ps2_mouse_cursor_tracker_core.sv
// channel  dir  payload                                      request moves
// mouse    in   mouse_byte                                   one raw mouse byte
// cursor   out  cursor_x/y, left/right/middle, dropped flag  one packet result
// cfg      in   cfg_we, cfg_index, cfg_data                  one register write
//
// one byte accepted per cycle while no held result stalls the input; a byte
// passes an input register, then the packet assembler and cursor update
// settle into the result register when the packet-completing byte is consumed.
// reset clears position, buttons and byte position; registers take defaults.
// a held result stalls only a packet-completing byte; other bytes keep flowing.
module ps2_mouse_cursor_tracker_core #(
    parameter int PACKET_LEN = ps2mct_pkg::PACKET_LEN
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    ps2mct_byte_if.sink                          mouse,
    ps2mct_cursor_if.source                      cursor,
    input  logic                                 cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ps2mct_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import ps2mct_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic                 byte_vld_reg, byte_vld_next;
    logic [BYTE_BITS-1:0] byte_reg, byte_next;
    packet_t              pkt;
    logic                 out_free;
    logic                 advance;
    logic                 fire;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_STEP_SIZE:     cfg_next.step_size     = cfg_data[STEP_BITS-1:0];
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[RES_BITS-1:0];
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[RES_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    assign advance     = !pkt.done || out_free;
    assign fire        = byte_vld_reg && advance;
    assign mouse.ready = !byte_vld_reg || advance;

    always_comb
    begin
        byte_vld_next = byte_vld_reg;
        byte_next     = byte_reg;
        if (fire)
        begin
            byte_vld_next = 1'b0;
        end
        if (mouse.valid && mouse.ready)
        begin
            byte_vld_next = 1'b1;
            byte_next     = mouse.mouse_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size     <= STEP_RESET;
            cfg_reg.screen_width  <= WIDTH_RESET;
            cfg_reg.screen_height <= HEIGHT_RESET;
            byte_vld_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            byte_vld_reg <= byte_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    ps2mct_assembler #(
        .PACKET_LEN (PACKET_LEN)
    ) u_assembler (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_vld  (byte_vld_reg),
        .byte_data (byte_reg),
        .fire      (fire),
        .pkt       (pkt)
    );

    ps2mct_update u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .pkt      (pkt),
        .fire     (fire),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .cursor   (cursor)
    );

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !mouse.ready |-> (cursor.valid && !cursor.ready && byte_vld_reg && pkt.done))
        else $error("input stalled without a blocked result");

    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !(mouse.valid && mouse.ready)) |=> !byte_vld_reg)
        else $error("consumed byte still marked valid");

endmodule

FILE: sv/ps2mct_assembler.sv
module ps2mct_assembler #(
    parameter int PACKET_LEN = ps2mct_pkg::PACKET_LEN
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             byte_vld,
    input  logic [ps2mct_pkg::BYTE_BITS-1:0] byte_data,
    input  logic                             fire,
    output ps2mct_pkg::packet_t              pkt
);
    import ps2mct_pkg::*;

    localparam int POS_BITS = $clog2(PACKET_LEN);
    localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(PACKET_LEN - 1);

    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [BYTE_BITS-1:0] status_reg, status_next;
    logic [BYTE_BITS-1:0] dx_reg, dx_next;
    logic [BYTE_BITS-1:0] dy_reg, dy_next;

    always_comb
    begin
        pos_next    = pos_reg;
        status_next = status_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        if (fire && !(pos_reg == POS_BITS'(0) && !byte_data[BIT_ALWAYS]))
        begin
            if (pos_reg == POS_BITS'(0))
            begin
                status_next = byte_data;
            end
            else if (pos_reg == POS_BITS'(1))
            begin
                dx_next = byte_data;
            end
            else if (pos_reg == POS_BITS'(2))
            begin
                dy_next = byte_data;
            end
            if (pos_reg == LAST_POS)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            status_reg <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            status_reg <= status_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
        end
    end

    // dy byte is passed through live; last byte only sets done
    always_comb
    begin
        pkt.done   = byte_vld && (pos_reg == LAST_POS);
        pkt.status = status_reg;
        pkt.dx     = dx_reg;
        pkt.dy     = (pos_reg == POS_BITS'(2)) ? byte_data : dy_reg;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position beyond packet length");

endmodule

FILE: sv/ps2mct_update.sv
module ps2mct_update (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ps2mct_pkg::packet_t   pkt,
    input  logic                  fire,
    input  ps2mct_pkg::cfg_t      cfg,
    output logic                  out_free,
    ps2mct_cursor_if.source       cursor
);
    import ps2mct_pkg::*;

    localparam int VW = COORD_BITS + 3;
    localparam logic signed [VW-1:0] LO_BOUND  = VW'(2);
    localparam logic signed [VW-1:0] COORD_MAX = VW'((1 << COORD_BITS) - 1);

    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic [2:0]            btn_reg, btn_next;
    logic                  out_vld_reg, out_vld_next;
    logic                  drop_reg, drop_next;

    logic                  dropped;
    logic                  x_neg, x_pos, y_neg, y_pos;
    logic signed [VW-1:0]  step_s, vx, vy, dx_s, dy_s;

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [VW-1:0] v,
                                                    input logic [RES_BITS-1:0] res);
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] r;
        hi = $signed(VW'(res)) - VW'(2);
        if (hi < LO_BOUND)
        begin
            hi = LO_BOUND;
        end
        if (hi > COORD_MAX)
        begin
            hi = COORD_MAX;
        end
        r = v;
        if (r < LO_BOUND)
        begin
            r = LO_BOUND;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        dropped = pkt.status[BIT_X_OVF] || pkt.status[BIT_Y_OVF];
        x_neg   = pkt.status[BIT_X_SIGN];
        y_neg   = pkt.status[BIT_Y_SIGN];
        x_pos   = !x_neg && (pkt.dx != '0);
        y_pos   = !y_neg && (pkt.dy != '0);
        step_s  = $signed(VW'(cfg.step_size));

        dx_s = '0;
        if (x_neg)
        begin
            dx_s = -step_s;
        end
        else if (x_pos)
        begin
            dx_s = step_s;
        end

        // screen y grows downward
        dy_s = '0;
        if (y_neg)
        begin
            dy_s = step_s;
        end
        else if (y_pos)
        begin
            dy_s = -step_s;
        end

        vx = $signed(VW'(pos_x_reg)) + dx_s;
        vy = $signed(VW'(pos_y_reg)) + dy_s;

        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        btn_next     = btn_reg;
        drop_next    = drop_reg;
        out_vld_next = out_vld_reg;
        if (cursor.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (fire && pkt.done)
        begin
            out_vld_next = 1'b1;
            drop_next    = dropped;
            if (!dropped)
            begin
                btn_next   = pkt.status[BIT_MIDDLE:BIT_LEFT];
                pos_x_next = clamp(vx, cfg.screen_width);
                pos_y_next = clamp(vy, cfg.screen_height);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            btn_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            btn_reg     <= btn_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drop_reg <= drop_next;
    end

    assign out_free                = !out_vld_reg || cursor.ready;
    assign cursor.valid            = out_vld_reg;
    assign cursor.cursor_x         = pos_x_reg;
    assign cursor.cursor_y         = pos_y_reg;
    assign cursor.left_button      = btn_reg[BIT_LEFT];
    assign cursor.right_button     = btn_reg[BIT_RIGHT];
    assign cursor.middle_button    = btn_reg[BIT_MIDDLE];
    assign cursor.overflow_dropped = drop_reg;

    a_low_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !drop_reg) |-> (pos_x_reg >= COORD_BITS'(2) &&
                                        pos_y_reg >= COORD_BITS'(2)))
        else $error("cursor below lower clamp after a moving packet");

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2mct_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int RANDOM_PHASES = 5;

    typedef struct packed {
        logic [COORD_BITS-1:0] cursor_x;
        logic [COORD_BITS-1:0] cursor_y;
        logic                  left_button;
        logic                  right_button;
        logic                  middle_button;
        logic                  overflow_dropped;
    } cursor_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    ps2mct_byte_if   mouse_ch ();
    ps2mct_cursor_if cursor_ch ();

    ps2_mouse_cursor_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mouse     (mouse_ch),
        .cursor    (cursor_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // predicted tracker state
    logic [STEP_BITS-1:0]  step_q   = STEP_RESET;
    logic [RES_BITS-1:0]   width_q  = WIDTH_RESET;
    logic [RES_BITS-1:0]   height_q = HEIGHT_RESET;
    int                    pkt_pos  = 0;
    logic [BYTE_BITS-1:0]  status_hold_q = '0;
    logic [BYTE_BITS-1:0]  dx_hold_q = '0;
    logic [BYTE_BITS-1:0]  dy_hold_q = '0;
    logic [COORD_BITS-1:0] cur_x = '0;
    logic [COORD_BITS-1:0] cur_y = '0;
    logic [2:0]            buttons_q = '0;

    cursor_result_t expected_cursor [$];

    int error_count   = 0;
    int bytes_used    = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int dropped_seen  = 0;
    int config_writes = 0;

    // sender and receiver pacing
    bit tx_gaps   = 1'b0;
    bit rx_stalls = 1'b0;
    int burst_left = 0;
    int rx_hold_len = 0;
    int rx_run_left = 0;
    bit rx_ready_phase = 1'b1;

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v,
                                                          input logic [RES_BITS-1:0] res);
        int hi;
        hi = int'(res) - 2;
        if (hi < 2) hi = 2;
        if (hi > (1 << COORD_BITS) - 1) hi = (1 << COORD_BITS) - 1;
        if (v < 2) v = 2;
        if (v > hi) v = hi;
        return COORD_BITS'(v);
    endfunction

    function automatic void track_mouse_byte(input logic [BYTE_BITS-1:0] b);
        cursor_result_t r;
        logic drop;
        int sx;
        int sy;
        if (pkt_pos == 0 && !b[BIT_ALWAYS]) return;
        bytes_used++;
        case (pkt_pos)
            0: status_hold_q = b;
            1: dx_hold_q = b;
            2: dy_hold_q = b;
            default: ;
        endcase
        if (pkt_pos + 1 < PACKET_LEN)
        begin
            pkt_pos++;
            return;
        end
        pkt_pos = 0;
        drop = status_hold_q[BIT_X_OVF] | status_hold_q[BIT_Y_OVF];
        if (!drop)
        begin
            sx = status_hold_q[BIT_X_SIGN] ? -1 : (dx_hold_q != '0 ? 1 : 0);
            sy = status_hold_q[BIT_Y_SIGN] ? -1 : (dy_hold_q != '0 ? 1 : 0);
            buttons_q = {status_hold_q[BIT_MIDDLE], status_hold_q[BIT_RIGHT],
                         status_hold_q[BIT_LEFT]};
            cur_x = clamp_coord(int'(cur_x) + sx * int'(step_q), width_q);
            cur_y = clamp_coord(int'(cur_y) - sy * int'(step_q), height_q);
        end
        r.cursor_x         = cur_x;
        r.cursor_y         = cur_y;
        r.left_button      = buttons_q[0];
        r.right_button     = buttons_q[1];
        r.middle_button    = buttons_q[2];
        r.overflow_dropped = drop;
        expected_cursor.push_back(r);
    endfunction

    function automatic logic [BYTE_BITS-1:0] make_status(input logic x_ovf, input logic y_ovf,
                                                         input logic x_neg, input logic y_neg,
                                                         input logic [2:0] btn);
        logic [BYTE_BITS-1:0] s;
        s = '0;
        s[BIT_ALWAYS] = 1'b1;
        s[BIT_X_OVF]  = x_ovf;
        s[BIT_Y_OVF]  = y_ovf;
        s[BIT_X_SIGN] = x_neg;
        s[BIT_Y_SIGN] = y_neg;
        s[BIT_LEFT]   = btn[0];
        s[BIT_RIGHT]  = btn[1];
        s[BIT_MIDDLE] = btn[2];
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        if (tx_gaps && burst_left == 0)
        begin
            @(negedge clk);
            mouse_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        @(negedge clk);
        mouse_ch.valid      <= 1'b1;
        mouse_ch.mouse_byte <= b;
        do @(posedge clk); while (!mouse_ch.ready);
        bytes_sent++;
        track_mouse_byte(b);
    endtask

    task automatic send_packet(input logic [BYTE_BITS-1:0] status, input logic [BYTE_BITS-1:0] dx,
                               input logic [BYTE_BITS-1:0] dy, input logic [BYTE_BITS-1:0] wheel);
        logic [BYTE_BITS-1:0] pkt [4];
        pkt = '{status, dx, dy, wheel};
        for (int i = 0; i < PACKET_LEN; i++) send_byte(pkt[i]);
    endtask

    function automatic logic [BYTE_BITS-1:0] random_delta();
        return ($urandom_range(0, 4) == 0) ? '0 : BYTE_BITS'($urandom);
    endfunction

    task automatic send_random_packet(input int ovf_pct);
        logic [BYTE_BITS-1:0] s;
        s = make_status($urandom_range(0, 99) < ovf_pct, $urandom_range(0, 99) < ovf_pct,
                        1'($urandom), 1'($urandom), 3'($urandom));
        send_packet(s, random_delta(), random_delta(), BYTE_BITS'($urandom));
    endtask

    // sender waits for every expected result, then lets the pipeline settle
    task automatic drain_results();
        @(negedge clk);
        mouse_ch.valid <= 1'b0;
        while (expected_cursor.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        config_writes++;
        case (idx)
            CFG_STEP_SIZE:     step_q   = data[STEP_BITS-1:0];
            CFG_SCREEN_WIDTH:  width_q  = data[RES_BITS-1:0];
            CFG_SCREEN_HEIGHT: height_q = data[RES_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_BITS-1:0] step,
                              input logic [CFG_DATA_BITS-1:0] w,
                              input logic [CFG_DATA_BITS-1:0] h);
        drain_results();
        write_reg(CFG_STEP_SIZE, step);
        write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_and_special_cases();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        // bytes without the always-one bit at packet start
        send_byte(8'h00);
        send_byte(8'hF7);
        // overflow packets before any movement report the reset position
        send_packet(make_status(1'b1, 1'b0, 1'b0, 1'b0, 3'b111), 8'hFF, 8'hFF, 8'h00);
        send_packet(make_status(1'b0, 1'b1, 1'b1, 1'b1, 3'b101), 8'h01, 8'h80, 8'hFF);
        // zero deltas, clamp lifts the cursor off zero
        send_packet(make_status(1'b0, 1'b0, 1'b0, 1'b0, 3'b111), 8'h00, 8'h00, 8'h00);
        send_packet(make_status(1'b0, 1'b0, 1'b0, 1'b0, 3'b001), 8'hFF, 8'h00, 8'h55);
        // negative sign with zero byte still moves
        send_packet(make_status(1'b0, 1'b0, 1'b1, 1'b1, 3'b010), 8'h00, 8'h00, 8'hAA);
        send_packet(make_status(1'b0, 1'b0, 1'b1, 1'b0, 3'b100), 8'h80, 8'h7F, 8'hFF);
        drain_results();
    endtask

    task automatic test_register_extremes();
        logic [CFG_DATA_BITS-1:0] settings [6][3];
        settings = '{'{12'd0, 12'd1024, 12'd768}, '{12'd255, 12'd4, 12'd4},
                     '{12'd255, 12'd4095, 12'd4095}, '{12'hFFF, 12'd0, 12'd3},
                     '{12'd1, 12'd5, 12'd4095}, '{12'd200, 12'd300, 12'd4}};
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        foreach (settings[i])
        begin
            set_config(settings[i][0], settings[i][1], settings[i][2]);
            repeat (20) send_random_packet(10);
        end
        drain_results();
    endtask

    task automatic test_result_backpressure();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        set_config(12'd7, 12'd640, 12'd480);
        @(posedge clk);
        rx_hold_len = HOLD_OFF_LEN;
        repeat (16) send_random_packet(15);
        drain_results();
        rx_stalls = 1'b1;
    endtask

    task automatic test_random_traffic();
        int target;
        int kind;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if ($urandom_range(0, 1) == 0)
                set_config(($urandom_range(0, 3) == 0)
                               ? CFG_DATA_BITS'($urandom_range(0, 255))
                               : CFG_DATA_BITS'($urandom_range(1, 40)),
                           CFG_DATA_BITS'($urandom_range(4, 200)),
                           CFG_DATA_BITS'($urandom_range(4, 200)));
            else
                set_config(CFG_DATA_BITS'($urandom_range(0, 255)),
                           CFG_DATA_BITS'($urandom_range(4, 4095)),
                           CFG_DATA_BITS'($urandom_range(4, 4095)));
            // one phase runs with no idling on either side
            tx_gaps   = (phase != 2);
            rx_stalls = (phase != 2);
            target = bytes_used + 270;
            while (bytes_used < target)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 80)
                begin
                    send_random_packet(8);
                end
                else if (kind < 90)
                begin
                    send_byte(BYTE_BITS'($urandom));
                end
                else
                begin
                    // packet cut short
                    send_byte(make_status(1'b0, 1'b0, 1'($urandom), 1'($urandom),
                                          3'($urandom)));
                    repeat ($urandom_range(0, PACKET_LEN - 2)) send_byte(BYTE_BITS'($urandom));
                end
            end
        end
        drain_results();
    endtask

    // receiver pacing
    initial
    begin
        cursor_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                cursor_ch.ready <= 1'b0;
                rx_hold_len--;
            end
            else if (!rx_stalls)
            begin
                cursor_ch.ready <= 1'b1;
            end
            else
            begin
                if (rx_run_left == 0)
                begin
                    rx_ready_phase = !rx_ready_phase;
                    rx_run_left = rx_ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                rx_run_left--;
                cursor_ch.ready <= rx_ready_phase;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        cursor_result_t got;
        cursor_result_t want;
        if (rst_n && cursor_ch.valid && cursor_ch.ready)
        begin
            got.cursor_x         = cursor_ch.cursor_x;
            got.cursor_y         = cursor_ch.cursor_y;
            got.left_button      = cursor_ch.left_button;
            got.right_button     = cursor_ch.right_button;
            got.middle_button    = cursor_ch.middle_button;
            got.overflow_dropped = cursor_ch.overflow_dropped;
            results_seen++;
            dropped_seen += got.overflow_dropped;
            if (expected_cursor.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with none expected", results_seen));
            end
            else
            begin
                want = expected_cursor.pop_front();
                if (got.cursor_x !== want.cursor_x)
                    report_mismatch($sformatf("result %0d cursor_x %0d, expected %0d",
                                              results_seen, got.cursor_x, want.cursor_x));
                if (got.cursor_y !== want.cursor_y)
                    report_mismatch($sformatf("result %0d cursor_y %0d, expected %0d",
                                              results_seen, got.cursor_y, want.cursor_y));
                if (got.left_button !== want.left_button)
                    report_mismatch($sformatf("result %0d left_button %b, expected %b",
                                              results_seen, got.left_button,
                                              want.left_button));
                if (got.right_button !== want.right_button)
                    report_mismatch($sformatf("result %0d right_button %b, expected %b",
                                              results_seen, got.right_button,
                                              want.right_button));
                if (got.middle_button !== want.middle_button)
                    report_mismatch($sformatf("result %0d middle_button %b, expected %b",
                                              results_seen, got.middle_button,
                                              want.middle_button));
                if (got.overflow_dropped !== want.overflow_dropped)
                    report_mismatch($sformatf("result %0d overflow_dropped %b, expected %b",
                                              results_seen, got.overflow_dropped,
                                              want.overflow_dropped));
            end
        end
    end

    // watchdog on cycles with no request accepted
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((mouse_ch.valid && mouse_ch.ready) || (cursor_ch.valid && cursor_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        mouse_ch.valid      = 1'b0;
        mouse_ch.mouse_byte = '0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_and_special_cases();
        test_register_extremes();
        test_result_backpressure();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d mouse bytes (%0d used in packets), %0d register writes",
                 bytes_sent, bytes_used, config_writes);
        $display("checked %0d cursor results, %0d of them overflow drops, %0d mismatches",
                 results_seen, dropped_seen, error_count);
        if (error_count == 0 && expected_cursor.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/ps2mct_pkg.sv
sv/ps2mct_if.sv
sv/ps2mct_assembler.sv
sv/ps2mct_update.sv
sv/ps2_mouse_cursor_tracker_core.sv
tb/tb_top.sv
